// ===== rtl/gcd_lcm_unit_assert.svh =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit_assert.svh
// Assertion macros used by the checker file glu_check.sv.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GLU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GLU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit: next-cycle check failed");

`endif

// ===== rtl/glu_pkg.sv =====
// ----------------------------------------------------------------------------
// glu_pkg
// Types, status codes and microcode ROM of the gcd/lcm unit.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BOTH_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_EUCL,
    OP_DIV_LCM,
    OP_DIV_STEP,
    OP_ROTATE,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_FIN,
    OP_ZERO,
    OP_SEND
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_SMALL_ZERO,
    C_BIG_ZERO,
    C_CNT_LAST,
    C_OUT_READY
  } cond_t;

  typedef enum logic [3:0] {
    P_IDLE,
    P_TEST,
    P_DIV1,
    P_STEP1,
    P_SWAP,
    P_GCD,
    P_DIV2,
    P_STEP2,
    P_MULI,
    P_MSTEP,
    P_FIN,
    P_ZERO,
    P_OUT
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ctrl_t;

  // Control store: branch to jt when cond holds, else to jf.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      P_IDLE:  w = '{op: OP_LOAD,     cond: C_IN_VALID,   jt: P_TEST,  jf: P_IDLE};
      P_TEST:  w = '{op: OP_NOP,      cond: C_SMALL_ZERO, jt: P_GCD,   jf: P_DIV1};
      P_DIV1:  w = '{op: OP_DIV_EUCL, cond: C_ALWAYS,     jt: P_STEP1, jf: P_STEP1};
      P_STEP1: w = '{op: OP_DIV_STEP, cond: C_CNT_LAST,   jt: P_SWAP,  jf: P_STEP1};
      P_SWAP:  w = '{op: OP_ROTATE,   cond: C_ALWAYS,     jt: P_TEST,  jf: P_TEST};
      P_GCD:   w = '{op: OP_NOP,      cond: C_BIG_ZERO,   jt: P_ZERO,  jf: P_DIV2};
      P_DIV2:  w = '{op: OP_DIV_LCM,  cond: C_ALWAYS,     jt: P_STEP2, jf: P_STEP2};
      P_STEP2: w = '{op: OP_DIV_STEP, cond: C_CNT_LAST,   jt: P_MULI,  jf: P_STEP2};
      P_MULI:  w = '{op: OP_MUL_INIT, cond: C_ALWAYS,     jt: P_MSTEP, jf: P_MSTEP};
      P_MSTEP: w = '{op: OP_MUL_STEP, cond: C_CNT_LAST,   jt: P_FIN,   jf: P_MSTEP};
      P_FIN:   w = '{op: OP_FIN,      cond: C_ALWAYS,     jt: P_OUT,   jf: P_OUT};
      P_ZERO:  w = '{op: OP_ZERO,     cond: C_ALWAYS,     jt: P_OUT,   jf: P_OUT};
      P_OUT:   w = '{op: OP_SEND,     cond: C_OUT_READY,  jt: P_IDLE,  jf: P_OUT};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,     jt: P_IDLE,  jf: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Euclidean gcd and lcm of two unsigned operands, microcoded sequencer.
// ----------------------------------------------------------------------------
// Takes one transaction at a time and returns one result transaction for it.
// Division runs on the shared restoring divider, which produces one quotient
// bit per cycle, and multiplication on the shift-and-add multiplier, one
// multiplier bit per cycle. in_ready is high only while the sequencer sits
// at its idle step.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-2:0] first_value,
  input  logic [DATA_WIDTH-2:0] second_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-2:0] divisor,
  output logic [DATA_WIDTH-2:0] multiple,
  output logic [1:0]            status
);

  localparam int VW = DATA_WIDTH - 1;
  localparam int CW = $clog2(VW);
  localparam logic [CW-1:0] CNT_LAST = CW'(VW - 1);

  glu_pkg::step_t pc;
  glu_pkg::ctrl_t cw;
  logic           cond_true;

  logic [VW-1:0] opa;
  logic [VW-1:0] opb;
  logic [VW-1:0] big;
  logic [VW-1:0] lesser;
  logic [VW-1:0] dvd;
  logic [VW-1:0] dsr;
  logic [VW-1:0] rem;
  logic [VW-1:0] mq;
  logic [VW-1:0] acc;
  logic          ovf;
  logic [CW-1:0] cnt;

  logic [VW:0]   rshift;
  logic          qbit;
  logic [VW+1:0] psum;

  assign cw        = glu_pkg::ucode(pc);
  assign in_ready  = (cw.op == glu_pkg::OP_LOAD);
  assign out_valid = (cw.op == glu_pkg::OP_SEND);

  always_comb begin
    case (cw.cond)
      glu_pkg::C_ALWAYS:     cond_true = 1'b1;
      glu_pkg::C_IN_VALID:   cond_true = in_valid;
      glu_pkg::C_SMALL_ZERO: cond_true = (lesser == '0);
      glu_pkg::C_BIG_ZERO:   cond_true = (big == '0);
      glu_pkg::C_CNT_LAST:   cond_true = (cnt == CNT_LAST);
      glu_pkg::C_OUT_READY:  cond_true = out_ready;
      default:               cond_true = 1'b0;
    endcase
  end

  // divider step: shift next dividend bit into the partial remainder
  assign rshift = {rem, dvd[VW-1]};
  assign qbit   = (rshift >= {1'b0, dsr});

  // multiplier step, msb of quotient first
  assign psum = {1'b0, acc, 1'b0} + (mq[VW-1] ? {2'b00, opb} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= glu_pkg::P_IDLE;
    end else begin
      pc <= cond_true ? cw.jt : cw.jf;
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      glu_pkg::OP_LOAD: begin
        if (in_valid) begin
          opa <= first_value;
          opb <= second_value;
          if (first_value < second_value) begin
            big    <= second_value;
            lesser <= first_value;
          end else begin
            big    <= first_value;
            lesser <= second_value;
          end
        end
      end
      glu_pkg::OP_DIV_EUCL: begin
        dvd <= big;
        dsr <= lesser;
        rem <= '0;
        cnt <= '0;
      end
      glu_pkg::OP_DIV_LCM: begin
        dvd <= opa;
        dsr <= big;
        rem <= '0;
        cnt <= '0;
      end
      glu_pkg::OP_DIV_STEP: begin
        if (qbit) begin
          rem <= VW'(rshift - {1'b0, dsr});
        end else begin
          rem <= rshift[VW-1:0];
        end
        dvd <= {dvd[VW-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      glu_pkg::OP_ROTATE: begin
        big    <= lesser;
        lesser <= rem;
      end
      glu_pkg::OP_MUL_INIT: begin
        mq  <= dvd;
        acc <= '0;
        ovf <= 1'b0;
        cnt <= '0;
      end
      glu_pkg::OP_MUL_STEP: begin
        if (psum[VW+1:VW] != 2'b00) begin
          ovf <= 1'b1;
        end
        acc <= psum[VW-1:0];
        mq  <= {mq[VW-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      glu_pkg::OP_FIN: begin
        divisor <= big;
        if (ovf) begin
          multiple <= '1;
          status   <= glu_pkg::STATUS_OVERFLOW;
        end else begin
          multiple <= acc;
          status   <= glu_pkg::STATUS_OK;
        end
      end
      glu_pkg::OP_ZERO: begin
        divisor  <= '0;
        multiple <= '0;
        status   <= glu_pkg::STATUS_BOTH_ZERO;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/glu_check.sv =====
// ----------------------------------------------------------------------------
// glu_check
// Port-level checks of the gcd/lcm unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "gcd_lcm_unit_assert.svh"

module glu_check #(
  parameter int DATA_WIDTH = 64
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-2:0] divisor,
  input logic [DATA_WIDTH-2:0] multiple,
  input logic [1:0]            status
);

  // one transaction in flight at most
  `GLU_ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
  `GLU_ASSERT_IMPL(a_zero_result, out_valid && status == glu_pkg::STATUS_BOTH_ZERO, divisor == '0 && multiple == '0)
  `GLU_ASSERT_IMPL(a_zero_gcd, out_valid && divisor == '0, status == glu_pkg::STATUS_BOTH_ZERO)
  `GLU_ASSERT_IMPL(a_saturate, out_valid && status == glu_pkg::STATUS_OVERFLOW, multiple == '1)
  `GLU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(divisor) && $stable(multiple) && $stable(status))

endmodule

bind gcd_lcm_unit glu_check #(.DATA_WIDTH(DATA_WIDTH)) u_glu_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .divisor   (divisor),
  .multiple  (multiple),
  .status    (status)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gcd/lcm unit.
// ----------------------------------------------------------------------------
// Operand pairs are queued by the stimulus block and presented by a clocked
// driver under valid/ready. A clocked monitor predicts the gcd, lcm and status
// of every accepted transaction and checks each returned result against the
// oldest prediction. Covers both-zero, single-zero, exact-fit and saturating
// lcm, deep Euclid chains (Fibonacci pairs), and random operand classes, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int        OPW        = 63;
  localparam bit [63:0] VALUE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int        IDLE_PCT   = 23;
  localparam int        N_RANDOM   = 80;
  localparam int        STALL_MAX  = 50000;
  localparam int        DRAIN_WAIT = 6400;

  typedef struct {
    bit [OPW-1:0] a;
    bit [OPW-1:0] b;
    bit           hold;
  } operand_pair_t;

  typedef struct {
    bit [OPW-1:0] divisor;
    bit [OPW-1:0] multiple;
    bit [1:0]     status;
  } gcd_lcm_t;

  logic           clk          = 1'b0;
  logic           rst          = 1'b1;
  logic           in_valid     = 1'b0;
  logic           in_ready;
  logic [OPW-1:0] first_value  = '0;
  logic [OPW-1:0] second_value = '0;
  logic           out_valid;
  logic           out_ready    = 1'b0;
  logic [OPW-1:0] divisor;
  logic [OPW-1:0] multiple;
  logic [1:0]     status;

  operand_pair_t pending_pairs[$];
  gcd_lcm_t      predicted[$];

  int errors           = 0;
  int issued_cnt       = 0;
  int accepted_items   = 0;
  int returned_results = 0;
  int both_zero_cnt    = 0;
  int saturated_cnt    = 0;
  int stall_cycles     = 0;

  gcd_lcm_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_value  (first_value),
    .second_value (second_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .divisor      (divisor),
    .multiple     (multiple),
    .status       (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic gcd_lcm_t predict_gcd_lcm(bit [OPW-1:0] a, bit [OPW-1:0] b);
    gcd_lcm_t  r;
    bit [63:0] big;
    bit [63:0] lesser;
    bit [63:0] rem;
    bit [63:0] quot;
    if (a == 0 && b == 0) begin
      r.divisor  = '0;
      r.multiple = '0;
      r.status   = glu_pkg::STATUS_BOTH_ZERO;
      return r;
    end
    big    = (a >= b) ? {1'b0, a} : {1'b0, b};
    lesser = (a >= b) ? {1'b0, b} : {1'b0, a};
    while (lesser != 0) begin
      rem    = big % lesser;
      big    = lesser;
      lesser = rem;
    end
    quot      = {1'b0, a} / big;
    r.divisor = big[OPW-1:0];
    if (b != 0 && quot > VALUE_MAX / {1'b0, b}) begin
      r.multiple = VALUE_MAX[OPW-1:0];
      r.status   = glu_pkg::STATUS_OVERFLOW;
    end else begin
      r.multiple = quot[OPW-1:0] * b;
      r.status   = glu_pkg::STATUS_OK;
    end
    return r;
  endfunction

  function automatic bit [63:0] fibonacci(int n);
    bit [63:0] x;
    bit [63:0] y;
    bit [63:0] t;
    x = 0;
    y = 1;
    for (int i = 0; i < n; i++) begin
      t = x + y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit [OPW-1:0] rand_operand();
    bit [63:0] v;
    v = {$urandom, $urandom};
    return v[OPW-1:0];
  endfunction

  task automatic queue_pair(bit [63:0] a, bit [63:0] b, bit hold = 1'b0);
    operand_pair_t p;
    p.a    = a[OPW-1:0];
    p.b    = b[OPW-1:0];
    p.hold = hold;
    pending_pairs = {pending_pairs, p};
  endtask

  task automatic queue_random_pair(bit hold);
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] g;
    int        k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = rand_operand();
        b = rand_operand();
      end
      3: begin
        k = $urandom_range(1, 30);
        g = ({$urandom, $urandom} >> (64 - k)) | 64'd1;
        a = g * ({$urandom, $urandom} >> (k + 1));
        b = g * ({$urandom, $urandom} >> (k + 1));
      end
      4: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      5: begin
        a = $urandom_range(0, 1) ? rand_operand() : 64'd0;
        b = (a == 0) ? rand_operand() : 64'd0;
      end
      6: begin
        k = $urandom_range(2, 92);
        a = fibonacci(k);
        b = fibonacci(k - 1);
        if ($urandom_range(0, 1)) begin
          g = a;
          a = b;
          b = g;
        end
      end
      7: begin
        a = {$urandom, $urandom} >> $urandom_range(31, 34);
        b = {$urandom, $urandom} >> $urandom_range(31, 34);
      end
      8: begin
        b = rand_operand() >> $urandom_range(8, 62);
        a = b * $urandom_range(1, 4096);
      end
      default: begin
        a = rand_operand() >> $urandom_range(0, 62);
        b = rand_operand() >> $urandom_range(0, 62);
      end
    endcase
    queue_pair(a, b, hold);
  endtask

  // driver
  always @(posedge clk) begin : drive
    operand_pair_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_pairs.size() != 0
          && ((issued_cnt >= 50 && issued_cnt < 80) || $urandom_range(0, 99) >= IDLE_PCT)
          && (!pending_pairs[0].hold
              || (!in_valid && accepted_items == returned_results))) begin
        p = pending_pairs.pop_front();
        first_value  <= p.a;
        second_value <= p.b;
        in_valid     <= 1'b1;
        issued_cnt   <= issued_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and prediction
  always @(posedge clk) begin : watch
    gcd_lcm_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (returned_results >= 50 && returned_results < 80)
                   || $urandom_range(0, 99) >= IDLE_PCT;
      if (out_valid && out_ready) begin
        returned_results <= returned_results + 1;
        if (predicted.size() == 0) begin
          errors++;
          $error("result with nothing outstanding: divisor %0d multiple %0d status %0d",
                 divisor, multiple, status);
        end else begin
          e = predicted.pop_front();
          if (e.status == glu_pkg::STATUS_BOTH_ZERO) both_zero_cnt++;
          if (e.status == glu_pkg::STATUS_OVERFLOW) saturated_cnt++;
          if (divisor !== e.divisor) begin
            errors++;
            $error("divisor: expected %0d, got %0d", e.divisor, divisor);
          end
          if (multiple !== e.multiple) begin
            errors++;
            $error("multiple: expected %0d, got %0d", e.multiple, multiple);
          end
          if (status !== e.status) begin
            errors++;
            $error("status: expected %0d, got %0d", e.status, status);
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = {predicted, predict_gcd_lcm(first_value, second_value)};
        accepted_items <= accepted_items + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("watchdog: no transaction for %0d cycles", STALL_MAX);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    queue_pair(0, 0);
    queue_pair(0, 12345);
    queue_pair(VALUE_MAX, 0);
    queue_pair(1, 1);
    queue_pair(VALUE_MAX, VALUE_MAX);
    queue_pair(VALUE_MAX, 1);
    queue_pair(1, VALUE_MAX);
    queue_pair(VALUE_MAX, VALUE_MAX - 1);
    queue_pair(12, 18);
    queue_pair(18, 12);
    queue_pair(49, VALUE_MAX / 49);
    queue_pair(3, 64'd1 << 62);
    queue_pair(2, 64'd1 << 62);
    queue_pair(2, (64'd1 << 62) + 1);
    queue_pair(fibonacci(92), fibonacci(91), 1'b1);
    queue_pair(fibonacci(91), fibonacci(92));
    queue_pair(64'd1 << 62, 64'd1 << 61);
    queue_pair(64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA);
    queue_pair(0, 0);
    queue_pair(64'd1 << 62, VALUE_MAX);
    for (int i = 0; i < N_RANDOM; i++) queue_random_pair(i == 30);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || in_valid || predicted.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (predicted.size() != 0) begin
      errors += predicted.size();
      $error("%0d predicted results never returned", predicted.size());
    end
    $display("Ran %0d operand pairs (directed edges, Fibonacci chains, random classes);",
             accepted_items);
    $display("checked %0d results, %0d both-zero, %0d saturated lcm, %0d mismatches.",
             returned_results, both_zero_cnt, saturated_cnt, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
